FILE: rtl/core/robin_hood_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Robin Hood hash table assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhh assertion failed");

`endif

FILE: rtl/core/rhh_pkg.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table package
// Sizes, slot layout, status codes and controller-to-datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

package rhh_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int CNT_BITS    = SLOT_BITS + 1;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int LIMIT_BITS  = 10;
    localparam int FIELD_BITS  = 32;
    localparam int OP_BITS     = 2;
    localparam int STAT_BITS   = 3;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(512);
    localparam logic [CNT_BITS-1:0]   MAX_COUNT   = CNT_BITS'(TABLE_SLOTS - 1);

    localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FOUND     = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_INSERTED  = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_UPDATED   = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd5;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_READ,
        DP_FIND_NEXT,
        DP_FOUND,
        DP_UPDATE,
        DP_INS_START,
        DP_INS_STEP,
        DP_DEL_START,
        DP_DEL_STEP,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        logic                     used;
        logic [KEY_BITS-1:0]      key;
        logic [VALUE_BITS-1:0]    value;
        logic [SLOT_BITS-1:0]     distance;
    } t_slot;

    typedef struct packed {
        t_dp_op                   op;
        logic [STAT_BITS-1:0]     status;
    } t_dp_cmd;

    typedef struct packed {
        logic                     clear_last;
        logic                     slot_used;
        logic                     key_match;
        logic                     probe_over;
        logic                     ins_stop;
        logic                     del_stop;
        logic                     is_full;
        logic                     out_free;
        logic [OP_BITS-1:0]       opcode;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/rhh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/rhh_dp.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table datapath
// Slot memory, probe registers, carried entry, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "robin_hood_hash_table_macros.svh"

module rhh_dp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire rhh_pkg::t_dp_cmd                   i_cmd,
    output rhh_pkg::t_dp_stat                       o_stat,
    input  wire logic                               i_cfg_we,
    input  wire logic [rhh_pkg::LIMIT_BITS-1:0]     i_cfg_wdata,
    input  wire logic [rhh_pkg::OP_BITS-1:0]        i_opcode,
    input  wire logic [rhh_pkg::FIELD_BITS-1:0]     i_key,
    input  wire logic [rhh_pkg::FIELD_BITS-1:0]     i_hash,
    input  wire logic [rhh_pkg::FIELD_BITS-1:0]     i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [rhh_pkg::STAT_BITS-1:0]      o_status,
    output logic      [rhh_pkg::FIELD_BITS-1:0]     o_read_value,
    output logic      [rhh_pkg::CNT_BITS-1:0]       o_count
);

    import rhh_pkg::*;

    logic [LIMIT_BITS-1:0] r_limit;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [SLOT_BITS-1:0]  r_clr, n_clr;
    logic [OP_BITS-1:0]    r_op, n_op;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [SLOT_BITS-1:0]  r_home, n_home;
    logic [SLOT_BITS-1:0]  r_idx, n_idx;
    logic [SLOT_BITS-1:0]  r_hole, n_hole;
    logic [VALUE_BITS-1:0] r_rv, n_rv;
    t_slot                 r_saved, n_saved;
    t_slot                 r_carry, n_carry;
    logic                  r_ovalid, n_ovalid;
    logic [STAT_BITS-1:0]  r_ostat, n_ostat;
    logic [VALUE_BITS-1:0] r_orv, n_orv;
    logic [CNT_BITS-1:0]   r_ocnt, n_ocnt;

    t_slot                 rd_slot;
    t_slot                 wr_slot;
    logic                  wr_en;
    logic [SLOT_BITS-1:0]  wr_addr;
    logic [SLOT_BITS-1:0]  probe_dist;

    rhh_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_slot),
        .i_raddr (r_idx),
        .o_rdata (rd_slot)
    );

    assign probe_dist = r_idx - r_home;

    always_comb begin
        o_stat.clear_last = &r_clr;
        o_stat.slot_used  = rd_slot.used;
        o_stat.key_match  = rd_slot.key == r_key;
        o_stat.probe_over = probe_dist > rd_slot.distance;
        o_stat.ins_stop   = !rd_slot.used;
        o_stat.del_stop   = !rd_slot.used || rd_slot.distance == '0;
        o_stat.is_full    = r_count >= {1'b0, r_limit} || r_count >= MAX_COUNT;
        o_stat.out_free   = !r_ovalid || i_out_ready;
        o_stat.opcode     = r_op;
    end

    always_comb begin
        n_count  = r_count;
        n_clr    = r_clr;
        n_op     = r_op;
        n_key    = r_key;
        n_val    = r_val;
        n_home   = r_home;
        n_idx    = r_idx;
        n_hole   = r_hole;
        n_rv     = r_rv;
        n_saved  = r_saved;
        n_carry  = r_carry;
        n_ovalid = r_ovalid && !i_out_ready;
        n_ostat  = r_ostat;
        n_orv    = r_orv;
        n_ocnt   = r_ocnt;
        wr_en    = 1'b0;
        wr_addr  = r_idx;
        wr_slot  = r_carry;
        unique case (i_cmd.op)
            DP_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = r_clr;
                wr_slot      = '0;
                n_clr        = r_clr + 1'b1;
            end
            DP_LOAD: begin
                n_op   = i_opcode;
                n_key  = i_key[KEY_BITS-1:0];
                n_val  = i_value[VALUE_BITS-1:0];
                n_home = i_hash[SLOT_BITS-1:0];
                n_idx  = i_hash[SLOT_BITS-1:0];
                n_rv   = '0;
            end
            DP_FIND_NEXT: begin
                n_idx = r_idx + 1'b1;
            end
            DP_FOUND: begin
                n_rv    = rd_slot.value;
                n_saved = rd_slot;
            end
            DP_UPDATE: begin
                wr_en         = 1'b1;
                wr_slot       = r_saved;
                wr_slot.value = r_val;
            end
            DP_INS_START: begin
                n_idx            = r_home;
                n_carry.used     = 1'b1;
                n_carry.key      = r_key;
                n_carry.value    = r_val;
                n_carry.distance = '0;
            end
            DP_INS_STEP: begin
                if (!rd_slot.used) begin
                    wr_en   = 1'b1;
                    n_count = r_count + 1'b1;
                end else if (r_carry.distance > rd_slot.distance) begin
                    wr_en            = 1'b1;
                    n_carry          = rd_slot;
                    n_carry.distance = rd_slot.distance + 1'b1;
                    n_idx            = r_idx + 1'b1;
                end else begin
                    n_carry.distance = r_carry.distance + 1'b1;
                    n_idx            = r_idx + 1'b1;
                end
            end
            DP_DEL_START: begin
                n_count = r_count - 1'b1;
                n_hole  = r_idx;
                n_idx   = r_idx + 1'b1;
            end
            DP_DEL_STEP: begin
                wr_en   = 1'b1;
                wr_addr = r_hole;
                if (!rd_slot.used || rd_slot.distance == '0) begin
                    wr_slot = '0;
                end else begin
                    wr_slot          = rd_slot;
                    wr_slot.distance = rd_slot.distance - 1'b1;
                    n_hole           = r_idx;
                    n_idx            = r_idx + 1'b1;
                end
            end
            DP_RESULT: begin
                n_ovalid = 1'b1;
                n_ostat  = i_cmd.status;
                n_orv    = r_rv;
                n_ocnt   = r_count;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= LIMIT_RESET;
            r_count  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_count  <= n_count;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
        r_op    <= n_op;
        r_key   <= n_key;
        r_val   <= n_val;
        r_home  <= n_home;
        r_idx   <= n_idx;
        r_hole  <= n_hole;
        r_rv    <= n_rv;
        r_saved <= n_saved;
        r_carry <= n_carry;
        r_ostat <= n_ostat;
        r_orv   <= n_orv;
        r_ocnt  <= n_ocnt;
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostat;
    assign o_read_value = FIELD_BITS'(r_orv);
    assign o_count      = r_ocnt;

    `RHH_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAX_COUNT)
    `RHH_ASSERT_IMPL(a_ins_not_full, i_clk, i_rst_n, i_cmd.op == DP_INS_START,
        !o_stat.is_full)
    `RHH_ASSERT_IMPL(a_del_nonempty, i_clk, i_rst_n, i_cmd.op == DP_DEL_START,
        r_count != '0)

endmodule

`default_nettype wire

FILE: rtl/core/rhh_ctrl.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table controller
// Sequences the clearing pass, probe walk, insert chain and back-shift delete.
// ----------------------------------------------------------------------------
`default_nettype none
`include "robin_hood_hash_table_macros.svh"

module rhh_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire rhh_pkg::t_dp_stat i_stat,
    output rhh_pkg::t_dp_cmd       o_cmd
);

    import rhh_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FRD   = 4'd2;
    localparam logic [3:0] S_FCHK  = 4'd3;
    localparam logic [3:0] S_FHIT  = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_DSTRT = 4'd6;
    localparam logic [3:0] S_DRD   = 4'd7;
    localparam logic [3:0] S_DCHK  = 4'd8;
    localparam logic [3:0] S_IRD   = 4'd9;
    localparam logic [3:0] S_ICHK  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]           r_state, n_state;
    logic [STAT_BITS-1:0] r_res, n_res;
    logic                 accept;

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state       = r_state;
        n_res         = r_res;
        o_cmd.op      = DP_NOP;
        o_cmd.status  = r_res;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = DP_LOAD;
                    n_state  = S_FRD;
                end
            end
            S_FRD: begin
                o_cmd.op = DP_READ;
                n_state  = S_FCHK;
            end
            S_FCHK: begin
                n_res = ST_NOT_FOUND;
                if (i_stat.opcode != OP_LOOKUP && i_stat.opcode != OP_INSERT &&
                    i_stat.opcode != OP_REMOVE) begin
                    n_state = S_DONE;
                end else if (!i_stat.slot_used || (!i_stat.key_match &&
                             i_stat.probe_over)) begin
                    if (i_stat.opcode != OP_INSERT) begin
                        n_state = S_DONE;
                    end else if (i_stat.is_full) begin
                        n_res   = ST_FULL;
                        n_state = S_DONE;
                    end else begin
                        o_cmd.op = DP_INS_START;
                        n_state  = S_IRD;
                    end
                end else if (i_stat.key_match) begin
                    o_cmd.op = DP_FOUND;
                    n_state  = S_FHIT;
                end else begin
                    o_cmd.op = DP_FIND_NEXT;
                    n_state  = S_FRD;
                end
            end
            S_FHIT: begin
                if (i_stat.opcode == OP_INSERT) begin
                    n_state = S_UPD;
                end else if (i_stat.opcode == OP_REMOVE) begin
                    n_state = S_DSTRT;
                end else begin
                    n_res   = ST_FOUND;
                    n_state = S_DONE;
                end
            end
            S_UPD: begin
                o_cmd.op = DP_UPDATE;
                n_res    = ST_UPDATED;
                n_state  = S_DONE;
            end
            S_DSTRT: begin
                o_cmd.op = DP_DEL_START;
                n_state  = S_DRD;
            end
            S_DRD: begin
                o_cmd.op = DP_READ;
                n_state  = S_DCHK;
            end
            S_DCHK: begin
                o_cmd.op = DP_DEL_STEP;
                if (i_stat.del_stop) begin
                    n_res   = ST_REMOVED;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DRD;
                end
            end
            S_IRD: begin
                o_cmd.op = DP_READ;
                n_state  = S_ICHK;
            end
            S_ICHK: begin
                o_cmd.op = DP_INS_STEP;
                if (i_stat.ins_stop) begin
                    n_res   = ST_INSERTED;
                    n_state = S_DONE;
                end else begin
                    n_state = S_IRD;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = DP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
        r_res <= n_res;
    end

    `RHH_ASSERT_NEXT(a_accept_probes, i_clk, i_rst_n, accept, r_state == S_FRD)
    `RHH_ASSERT_NEXT(a_result_idle, i_clk, i_rst_n, o_cmd.op == DP_RESULT,
        r_state == S_IDLE)
    `RHH_ASSERT_IMPL(a_result_free, i_clk, i_rst_n, o_cmd.op == DP_RESULT,
        i_stat.out_free)

endmodule

`default_nettype wire

FILE: rtl/core/robin_hood_hash_table.sv
// ----------------------------------------------------------------------------
// Robin Hood hash table
// Open-addressing key/value table with Robin Hood probing and back-shift
// delete.
//
// Usage: one item is a lookup, an insert-or-update or a remove, sent on the
// input valid/ready channel with key, externally computed hash and value.
// Each item yields one result transfer on the output valid/ready channel
// with status, the stored value when the key was found, and the entry count.
// One item is worked at a time. The probe, and then any insert chain or
// back-shift run, reads one slot at a time through the single read port of
// the slot memory. Input ready returns in the cycle output valid rises.
// After reset the block runs a clearing pass over the slot memory, with
// input ready low; the load limit register returns to 512.
// A finished result is held in the output register while the receiver stalls;
// the next item may be accepted, but its result waits, with input ready low,
// until the held transfer completes.
// ----------------------------------------------------------------------------
`default_nettype none

module robin_hood_hash_table (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rhh_pkg::LIMIT_BITS-1:0]     i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [rhh_pkg::OP_BITS-1:0]        i_opcode,
    input  wire logic [rhh_pkg::FIELD_BITS-1:0]     i_key,
    input  wire logic [rhh_pkg::FIELD_BITS-1:0]     i_hash,
    input  wire logic [rhh_pkg::FIELD_BITS-1:0]     i_value,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic      [rhh_pkg::STAT_BITS-1:0]      o_status,
    output logic      [rhh_pkg::FIELD_BITS-1:0]     o_read_value,
    output logic      [rhh_pkg::CNT_BITS-1:0]       o_count
);

    import rhh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rhh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rhh_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .i_hash       (i_hash),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_read_value (o_read_value),
        .o_count      (o_count)
    );

endmodule

`default_nettype wire
